[rtl/dwld_pkg.sv]
// ----------------------------------------------------------------------------
// dwld_pkg: shared constants for the dual white LED dimmer
// Level ranges, PWM period, fan curve points and the reciprocal constants
// used by the iterative multiplier sequence.
// ----------------------------------------------------------------------------
package dwld_pkg;

	localparam int unsigned LUM_TOP       = 512;
	localparam int unsigned MAX_COLOR     = 128;
	localparam int unsigned PWM_PERIOD    = 2048;

	// Field widths.
	localparam int unsigned LUM_W   = 10;
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned CNT_W   = 17;
	localparam int unsigned TEMP_W  = 16;
	localparam int unsigned DUTY_W  = 12;
	localparam int unsigned FAN_W   = 8;

	// Shared multiplier operand widths.
	localparam int unsigned MUL_A_W = 19;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

	// Reset values.
	localparam logic [CNT_W-1:0]   COLOR_REPEAT_RST = 17'd100000;
	localparam logic [CNT_W-1:0]   LUM_REPEAT_RST   = 17'd50000;
	localparam logic [TEMP_W-1:0]  OVERHEAT_THR_RST = 16'd60000;
	localparam logic [LUM_W-1:0]   OVERHEAT_LUM_RST = 10'd128;
	localparam logic [COLOR_W-1:0] COLOR_RST        = 8'(MAX_COLOR / 2);
	localparam logic [FAN_W-1:0]   FAN_RST          = 8'd200;

	// Fan curve.
	localparam logic [TEMP_W-1:0] FAN_LOW_TEMP  = 16'd35000;
	localparam logic [TEMP_W-1:0] FAN_HIGH_TEMP = 16'd50000;
	localparam logic [FAN_W-1:0]  FAN_MIN_DUTY  = 8'd10;
	localparam logic [FAN_W-1:0]  FAN_MAX_DUTY  = 8'd255;
	localparam logic [FAN_W-1:0]  FAN_OFF_DUTY  = 8'd0;

	// x/3 as (x*683)>>11, exact for x below 2048.
	localparam logic [MUL_B_W-1:0] RECIP_3       = 17'd683;
	localparam int unsigned        RECIP_3_SHIFT = 11;
	// x/170 as (x*98690)>>24, exact for x below 199728.
	localparam logic [MUL_B_W-1:0] RECIP_170     = 17'd98690;
	// x/250 as (x*67109)>>24, exact for x below 493447.
	localparam logic [MUL_B_W-1:0] RECIP_250     = 17'd67109;
	localparam int unsigned        RECIP_SHIFT   = 24;

	// Register map, index of the 32-bit word.
	localparam logic [1:0] REG_COLOR_REPEAT = 2'd0;
	localparam logic [1:0] REG_LUM_REPEAT   = 2'd1;
	localparam logic [1:0] REG_OVERHEAT_THR = 2'd2;
	localparam logic [1:0] REG_OVERHEAT_LUM = 2'd3;

endpackage

[rtl/dual_white_led_dimmer_with_hold_repeat.sv]
// ----------------------------------------------------------------------------
// dual_white_led_dimmer_with_hold_repeat: two-channel white LED dimmer
// Button stepping with hold repeat, cubic brightness curve, warm/cool
// duty split, fan curve and overheat luminance limit.
// ----------------------------------------------------------------------------
// Usage. Each input beat is one tick: the levels of the warm, cool, light and
// dark buttons plus an optional temperature sample. Every accepted beat
// produces exactly one output beat carrying the warm and cool LED compare
// values, the fan compare value and the current luminance and colour levels.
// Both channels use valid/ready; the configuration registers sit behind an
// APB-style port with byte addresses 0x0, 0x4, 0x8 and 0xC, always ready.
// Timing. The button and temperature updates happen at the accepting edge.
// The duties then come from one shared 19x17 multiplier, used six times in a
// row (L/3, L*L, cube, divide by 170, colour split, fan curve); the result
// is then loaded into the output register. The input is ready only while the
// sequencer is idle, so a new input beat is not accepted until the previous
// beat has finished its sequence.
// Stall. The result sits in an output register; a new item may be accepted
// while it waits, but that item's result holds in the final step until the
// output register has been emptied.
// Reset. All state returns to its reset values: colour at the middle, zero
// luminance, zero duties, fan at 200, and the registers at their defaults.
// ----------------------------------------------------------------------------
module dual_white_led_dimmer_with_hold_repeat
	import dwld_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Input channel.
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                warm_held,
	input  logic                cool_held,
	input  logic                light_held,
	input  logic                dark_held,
	input  logic                temp_valid,
	input  logic [TEMP_W-1:0]   temp_sample,
	// Output channel.
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DUTY_W-1:0]   warm_duty,
	output logic [DUTY_W-1:0]   cool_duty,
	output logic [FAN_W-1:0]    fan_duty,
	output logic [LUM_W-1:0]    luminance_now,
	output logic [COLOR_W-1:0]  color_now,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_L3,
		ST_SQ,
		ST_CUBE,
		ST_DIV,
		ST_WARM,
		ST_FAN,
		ST_DONE
	} state_t;

	state_t               state_q;

	// Configuration registers.
	logic [CNT_W-1:0]     color_repeat_q;
	logic [CNT_W-1:0]     lum_repeat_q;
	logic [TEMP_W-1:0]    overheat_thr_q;
	logic [LUM_W-1:0]     overheat_lum_q;

	// Block state.
	logic [3:0]           prev_btn_q;
	logic [COLOR_W-1:0]   color_q;
	logic [LUM_W-1:0]     lum_q;
	logic [CNT_W-1:0]     color_cnt_q;
	logic [CNT_W-1:0]     lum_cnt_q;
	logic [FAN_W-1:0]     fan_q;

	// Work registers of the sequence.
	logic                 tv_q;
	logic [TEMP_W-1:0]    temp_q;
	logic [PROD_W-1:0]    prod_q;
	logic [7:0]           l3_q;
	logic [LUM_W-1:0]     c_q;
	logic [DUTY_W-1:0]    warm_q;

	// Output register.
	logic                 out_valid_q;
	logic [DUTY_W-1:0]    out_warm_q;
	logic [DUTY_W-1:0]    out_cool_q;
	logic [FAN_W-1:0]     out_fan_q;
	logic [LUM_W-1:0]     out_lum_q;
	logic [COLOR_W-1:0]   out_color_q;

	logic                 in_fire;
	logic                 cfg_wr;
	logic                 out_free;
	logic [3:0]           btn;
	logic [3:0]           rise;
	logic                 color_held;
	logic                 lum_held;
	logic                 color_step;
	logic                 lum_step;
	logic [CNT_W-1:0]     color_cnt_inc;
	logic [CNT_W-1:0]     lum_cnt_inc;
	logic [CNT_W-1:0]     color_cnt_nxt;
	logic [CNT_W-1:0]     lum_cnt_nxt;
	logic [COLOR_W-1:0]   color_dn;
	logic [COLOR_W-1:0]   color_nxt;
	logic [LUM_W-1:0]     lum_dn;
	logic [LUM_W-1:0]     lum_up;
	logic [LUM_W-1:0]     lum_nxt;
	logic [LUM_W-1:0]     overheat_lum_sat;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic                 mul_en;
	logic [TEMP_W-1:0]    temp_off;
	logic [13:0]          temp_d;
	logic [TEMP_W-1:0]    temp_y;
	logic [FAN_W-1:0]     fan_nxt;
	logic [DUTY_W-1:0]    total_duty;
	logic [DUTY_W-1:0]    cool_nxt;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign out_free = !out_valid_q || out_ready;

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_COLOR_REPEAT: prdata = {15'd0, color_repeat_q};
			REG_LUM_REPEAT:   prdata = {15'd0, lum_repeat_q};
			REG_OVERHEAT_THR: prdata = {16'd0, overheat_thr_q};
			REG_OVERHEAT_LUM: prdata = {22'd0, overheat_lum_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Button edge detection and hold-repeat counters. A group steps on a new
	// press, or when its hold counter reaches the repeat count; a repeat count
	// of zero therefore fires on every held tick.
	always_comb begin
		btn        = {dark_held, light_held, cool_held, warm_held};
		rise       = btn & ~prev_btn_q;
		color_held = warm_held || cool_held;
		lum_held   = light_held || dark_held;

		color_cnt_inc = color_cnt_q + 1'b1;
		lum_cnt_inc   = lum_cnt_q + 1'b1;

		if (!color_held) begin
			color_step    = 1'b0;
			color_cnt_nxt = '0;
		end else if (rise[1:0] != 2'b00) begin
			color_step    = 1'b1;
			color_cnt_nxt = '0;
		end else if (color_cnt_inc >= color_repeat_q) begin
			color_step    = 1'b1;
			color_cnt_nxt = '0;
		end else begin
			color_step    = 1'b0;
			color_cnt_nxt = color_cnt_inc;
		end

		if (!lum_held) begin
			lum_step    = 1'b0;
			lum_cnt_nxt = '0;
		end else if (rise[3:2] != 2'b00) begin
			lum_step    = 1'b1;
			lum_cnt_nxt = '0;
		end else if (lum_cnt_inc >= lum_repeat_q) begin
			lum_step    = 1'b1;
			lum_cnt_nxt = '0;
		end else begin
			lum_step    = 1'b0;
			lum_cnt_nxt = lum_cnt_inc;
		end

		// Decrement first, then increment, each clamped at its bound.
		color_dn  = (warm_held && color_q != '0) ? color_q - 1'b1 : color_q;
		color_nxt = color_dn;
		if (color_step && cool_held && color_dn < COLOR_W'(MAX_COLOR)) begin
			color_nxt = color_dn + 1'b1;
		end else if (!color_step) begin
			color_nxt = color_q;
		end

		lum_dn = (dark_held && lum_q != '0) ? lum_q - 1'b1 : lum_q;
		lum_up = (light_held && lum_dn < LUM_W'(LUM_TOP)) ? lum_dn + 1'b1 : lum_dn;

		overheat_lum_sat = (overheat_lum_q > LUM_W'(LUM_TOP)) ?
			LUM_W'(LUM_TOP) : overheat_lum_q;

		lum_nxt = lum_step ? lum_up : lum_q;
		if (temp_valid && temp_sample > overheat_thr_q) begin
			lum_nxt = overheat_lum_sat;
		end
	end

	// Fan curve operand: 3*(t-35000), only used inside the ramp band.
	assign temp_off = temp_q - FAN_LOW_TEMP;
	assign temp_d   = temp_off[13:0];
	assign temp_y   = {2'b00, temp_d} + {1'b0, temp_d, 1'b0};

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (state_q)
			ST_L3: begin
				mul_a = MUL_A_W'(lum_q);
				mul_b = RECIP_3;
			end
			ST_SQ: begin
				mul_a = MUL_A_W'(lum_q);
				mul_b = MUL_B_W'(lum_q);
			end
			ST_CUBE: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(l3_q);
			end
			ST_DIV: begin
				// Cube divided by 512, then by 170 below.
				mul_a = MUL_A_W'(prod_q[25:9]);
				mul_b = RECIP_170;
			end
			ST_WARM: begin
				mul_a = MUL_A_W'(color_q);
				mul_b = MUL_B_W'(prod_q[RECIP_SHIFT +: LUM_W]);
			end
			ST_FAN: begin
				mul_a = MUL_A_W'(temp_y);
				mul_b = RECIP_250;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Final results.
	always_comb begin
		if (!tv_q) begin
			fan_nxt = fan_q;
		end else if (temp_q <= FAN_LOW_TEMP) begin
			fan_nxt = FAN_OFF_DUTY;
		end else if (temp_q < FAN_HIGH_TEMP) begin
			fan_nxt = FAN_MIN_DUTY + prod_q[RECIP_SHIFT +: FAN_W];
		end else begin
			fan_nxt = FAN_MAX_DUTY;
		end
		total_duty = {c_q, 2'b00};
		cool_nxt   = (total_duty >= warm_q) ? total_duty - warm_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			color_repeat_q <= COLOR_REPEAT_RST;
			lum_repeat_q   <= LUM_REPEAT_RST;
			overheat_thr_q <= OVERHEAT_THR_RST;
			overheat_lum_q <= OVERHEAT_LUM_RST;
			prev_btn_q     <= '0;
			color_q        <= COLOR_RST;
			lum_q          <= '0;
			color_cnt_q    <= '0;
			lum_cnt_q      <= '0;
			fan_q          <= FAN_RST;
			tv_q           <= 1'b0;
			temp_q         <= '0;
			prod_q         <= '0;
			l3_q           <= '0;
			c_q            <= '0;
			warm_q         <= '0;
			out_valid_q    <= 1'b0;
			out_warm_q     <= '0;
			out_cool_q     <= '0;
			out_fan_q      <= '0;
			out_lum_q      <= '0;
			out_color_q    <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_COLOR_REPEAT: color_repeat_q <= pwdata[CNT_W-1:0];
					REG_LUM_REPEAT:   lum_repeat_q   <= pwdata[CNT_W-1:0];
					REG_OVERHEAT_THR: overheat_thr_q <= pwdata[TEMP_W-1:0];
					REG_OVERHEAT_LUM: overheat_lum_q <= pwdata[LUM_W-1:0];
					default: begin
					end
				endcase
			end

			// A finished result refills the output register in the same
			// cycle that the previous beat leaves it.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (mul_en) begin
				prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						prev_btn_q  <= btn;
						color_cnt_q <= color_cnt_nxt;
						lum_cnt_q   <= lum_cnt_nxt;
						color_q     <= color_nxt;
						lum_q       <= lum_nxt;
						tv_q        <= temp_valid;
						temp_q      <= temp_sample;
						state_q     <= ST_L3;
					end
				end
				ST_L3: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					l3_q    <= prod_q[RECIP_3_SHIFT +: 8];
					state_q <= ST_CUBE;
				end
				ST_CUBE: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_WARM;
				end
				ST_WARM: begin
					c_q     <= prod_q[RECIP_SHIFT +: LUM_W];
					state_q <= ST_FAN;
				end
				ST_FAN: begin
					// Warm duty is colour*c/32.
					warm_q  <= prod_q[5 +: DUTY_W];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						fan_q       <= fan_nxt;
						out_warm_q  <= warm_q;
						out_cool_q  <= cool_nxt;
						out_fan_q   <= fan_nxt;
						out_lum_q   <= lum_q;
						out_color_q <= color_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign warm_duty     = out_warm_q;
	assign cool_duty     = out_cool_q;
	assign fan_duty      = out_fan_q;
	assign luminance_now = out_lum_q;
	assign color_now     = out_color_q;

endmodule
